/* rtl/core/erld_pkg.sv */
// Shared types and constants for the escape run-length decoder.
// No dependencies; every other file of the block but erld_stream_if refers to this package.
package erld_pkg;

  localparam int unsigned DICT_ENTRIES   = 16;
  localparam int unsigned DICT_ENTRY_W   = 8;
  localparam int unsigned DICT_W         = DICT_ENTRIES * DICT_ENTRY_W;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned COUNT_W        = 32;
  localparam int unsigned REPS_W         = 4;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [7:0] ESC_BYTE         = 8'h07;
  localparam logic [7:0] ESC_LITERAL_CODE = 8'h00;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DICT_LOW     = 2'd0,
    REG_DICT_HIGH    = 2'd1,
    REG_OUTPUT_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               group_last;
    logic [COUNT_W-1:0] written_count;
  } out_item_t;

  // One classified input byte: emit value reps times, then end the stream if last.
  typedef struct packed {
    logic [7:0]        value;
    logic [REPS_W-1:0] reps;
    logic              last;
  } cmd_t;

endpackage

/* rtl/core/erld_stream_if.sv */
// Valid/ready stream channel carrying one payload item per handshake.
// Depends on nothing; the payload type is given as a parameter at instantiation.
interface erld_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/escape_run_length_decoder_top.sv */
// Escape run-length decoder. Takes one compressed byte per handshake on
// compressed and gives decoded bytes on decoded. A literal byte gives one
// decoded byte and a run of n repeats n bytes, fewer when the output limit
// cuts it. A zero-repeat code, or a byte dropped once the limit is reached,
// is popped from the queue with no output. An escape byte that does not end
// the stream pushes no command. The run engine's single output register
// gives one decoded byte per cycle while decoded is ready. A command
// queue of QUEUE_DEPTH entries lets the input side take bytes while a run plays out.
// Configuration (dictionary words, output limit) is written on cfg_we/cfg_index/cfg_data;
// the user must write it only while the decoder is idle; the block does not enforce this.
module escape_run_length_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = erld_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  erld_stream_if.sink                      compressed,
  erld_stream_if.source                    decoded,
  input  logic                             cfg_we,
  input  logic [erld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [erld_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [erld_pkg::CFG_DATA_W-1:0] dict_low_word;
  logic [erld_pkg::CFG_DATA_W-1:0] dict_high_word;
  logic [erld_pkg::COUNT_W-1:0]    output_limit;

  logic           queue_full;
  logic           push;
  erld_pkg::cmd_t push_cmd;
  logic           pop;
  logic           head_valid;
  erld_pkg::cmd_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      dict_low_word  <= '0;
      dict_high_word <= '0;
      output_limit   <= erld_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        erld_pkg::REG_DICT_LOW:     dict_low_word  <= cfg_data;
        erld_pkg::REG_DICT_HIGH:    dict_high_word <= cfg_data;
        erld_pkg::REG_OUTPUT_LIMIT: output_limit   <= cfg_data[erld_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  erld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .compressed (compressed),
    .dict       ({dict_high_word, dict_low_word}),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  erld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  erld_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .output_limit (output_limit),
    .pop          (pop),
    .decoded      (decoded)
  );

endmodule

/* rtl/core/erld_front.sv */
// Front end: accepts compressed bytes, holds escapes and turns the rest
// into run commands with the dictionary lookup done. Uses erld_pkg.
module erld_front (
  input  logic                         clk,
  input  logic                         rst,
  erld_stream_if.sink                  compressed,
  input  logic [erld_pkg::DICT_W-1:0]  dict,
  input  logic                         queue_full,
  output logic                         push,
  output erld_pkg::cmd_t               cmd
);

  logic           escape_pending;
  logic           escape_pending_next;
  logic           accept;
  logic [7:0]     b;
  logic           last;
  logic [3:0]     idx;

  assign compressed.ready = !queue_full;
  assign accept = compressed.valid && compressed.ready;
  assign b      = compressed.data.in_byte;
  assign last   = compressed.data.in_last;
  assign idx    = b[3:0];

  always_comb begin
    push                = 1'b0;
    cmd.value           = b;
    cmd.reps            = erld_pkg::REPS_W'(1);
    cmd.last            = last;
    escape_pending_next = escape_pending;
    if (accept) begin
      priority if (escape_pending) begin
        push                = 1'b1;
        escape_pending_next = 1'b0;
        if (b == erld_pkg::ESC_LITERAL_CODE) begin
          cmd.value = erld_pkg::ESC_BYTE;
        end else begin
          cmd.value = dict[idx*erld_pkg::DICT_ENTRY_W +: erld_pkg::DICT_ENTRY_W];
          cmd.reps  = b[7:4];
        end
      end else if (b == erld_pkg::ESC_BYTE && !last) begin
        // hold the escape until its code byte arrives
        escape_pending_next = 1'b1;
      end else begin
        push = 1'b1;
      end
      if (last) begin
        escape_pending_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

/* rtl/core/erld_queue.sv */
// Small command FIFO between the front end and the run engine.
// Register based; uses erld_pkg for the command type.
module erld_queue #(
  parameter int unsigned DEPTH = erld_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  erld_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output erld_pkg::cmd_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  erld_pkg::cmd_t       slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     fill;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= CNT_W'(fill + 1'b1);
        2'b01:   fill <= CNT_W'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/core/erld_back.sv */
// Run engine: plays out the command at the queue head one byte per cycle while the output
// register is free, applies the output limit and drives the output register. Uses erld_pkg.
module erld_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  erld_pkg::cmd_t                head,
  input  logic [erld_pkg::COUNT_W-1:0]  output_limit,
  output logic                          pop,
  erld_stream_if.source                 decoded
);

  localparam int unsigned CW = erld_pkg::COUNT_W;
  localparam int unsigned RW = erld_pkg::REPS_W;

  logic [CW-1:0]        output_count;
  logic [CW-1:0]        output_count_next;
  logic                 limit_reached;
  logic                 limit_reached_next;
  logic [RW-1:0]        rep_done;
  logic [RW-1:0]        rep_done_next;
  logic [RW-1:0]        rep_inc;
  logic [CW-1:0]        count_inc;
  logic                 out_free;
  logic                 step;
  logic                 emit;
  logic                 glast;
  logic                 out_valid;
  erld_pkg::out_item_t  out_data;

  assign out_free  = !out_valid || decoded.ready;
  assign step      = head_valid && out_free;
  assign count_inc = CW'(output_count + 1'b1);
  assign rep_inc   = RW'(rep_done + 1'b1);

  always_comb begin
    pop                = 1'b0;
    emit               = 1'b0;
    glast              = 1'b0;
    output_count_next  = output_count;
    limit_reached_next = limit_reached;
    rep_done_next      = rep_done;
    if (step) begin
      priority if (head.reps == '0) begin
        pop = 1'b1;
      end else if (limit_reached || output_count >= output_limit) begin
        // refused write: drop the rest of the stream's output
        limit_reached_next = 1'b1;
        pop                = 1'b1;
      end else begin
        emit              = 1'b1;
        output_count_next = count_inc;
        if (rep_inc == head.reps) begin
          glast = 1'b1;
          pop   = 1'b1;
        end else if (count_inc >= output_limit) begin
          // next repeat would be refused: close the group now
          glast              = 1'b1;
          limit_reached_next = 1'b1;
          pop                = 1'b1;
        end else begin
          rep_done_next = rep_inc;
        end
      end
      if (pop) begin
        rep_done_next = '0;
        if (head.last) begin
          output_count_next  = '0;
          limit_reached_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_count  <= '0;
      limit_reached <= 1'b0;
      rep_done      <= '0;
      out_valid     <= 1'b0;
    end else begin
      output_count  <= output_count_next;
      limit_reached <= limit_reached_next;
      rep_done      <= rep_done_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (decoded.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_byte      <= head.value;
      out_data.group_last    <= glast;
      out_data.written_count <= count_inc;
    end
  end

  assign decoded.valid = out_valid;
  assign decoded.data  = out_data;

endmodule

/* rtl/core/erld_checker.sv */
// Port-level checks for the escape run-length decoder, bound to the top.
// Uses erld_pkg for the output item type.
module erld_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input erld_pkg::out_item_t out_data
);

  logic                         group_open;
  logic [erld_pkg::COUNT_W-1:0] prev_count;
  logic                         out_acc;

  assign out_acc = out_valid && out_ready;

  // track whether the last accepted byte left its group open
  always_ff @(posedge clk) begin
    if (rst) begin
      group_open <= 1'b0;
      prev_count <= '0;
    end else if (out_acc) begin
      group_open <= !out_data.group_last;
      prev_count <= out_data.written_count;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("decoded valid dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("decoded valid high right after reset");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.written_count != '0))
    else $error("written_count of zero on a decoded byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (out_acc && group_open) |->
      (out_data.written_count == erld_pkg::COUNT_W'(prev_count + 1'b1)))
    else $error("written_count did not advance by one within a group");

endmodule

bind escape_run_length_decoder_top erld_checker u_erld_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (decoded.valid),
  .out_ready (decoded.ready),
  .out_data  (decoded.data)
);
